/* sv/fbfl_pkg.sv */
`default_nettype none
package fbfl_pkg;

   // Pool geometry. Block indexes are 10 bits wide, so the pool holds at most 1024 blocks.
   localparam int MAX_BLOCKS = 1024;
   localparam int WORD_BYTES = 8;

   localparam int IDX_W    = 10;
   localparam int CNT_W    = 11;
   localparam int BYTES_W  = 16;
   localparam int OFF_W    = 26;
   localparam int STATUS_W = 2;
   localparam int STRIDE_W = 18;
   localparam int PROD_W   = IDX_W + STRIDE_W;

   localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0] POOL_LIMIT = CNT_W'(MAX_BLOCKS);

   // Request modes.
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // Configuration register indexes.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BLOCKS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES = 1'b1;

   typedef struct packed {
      logic             mode;
      logic [IDX_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    alloc_index;
      logic [OFF_W-1:0]    alloc_byte_offset;
      logic [CNT_W-1:0]    free_count;
   } rsp_type;

   // One entry of the freed-block stack: the block below and whether it exists.
   typedef struct packed {
      logic             below_valid;
      logic [IDX_W-1:0] next;
   } link_entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      link_entry_type   wr_data;
   } link_cmd_type;

endpackage
`default_nettype wire

/* sv/fixed_block_free_list_allocator_top.sv */
`default_nettype none
// Fixed-size block allocator. The pool is a LIFO free list: an allocate item pops the head
// block and returns its index and the byte offset of its payload, and a free item pushes an
// index back on the head. Freed blocks form a linked stack held in a synchronous link memory
// with a registered read, and it sits in front of a fresh-block counter, so a new pool hands
// out 0, 1, 2 and so on without any initialization pass. An item waits in a stage register,
// as the link of the head block is read from the memory in the cycle the item is accepted and
// comes back in the next cycle, and the next item must see the new head. Results leave through an
// output register, so the next item is accepted while a finished result still waits. There
// is no clearing pass after reset. Writing num_blocks restarts the pool (empty stack, counter
// cleared, free count reloaded); writing block_bytes only changes the offsets. Freeing an
// index at or above the pool size reports an error and changes nothing. Double frees are not
// detected, and the free count saturates at both ends.
module fixed_block_free_list_allocator_top (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire fbfl_pkg::req_type         req_data,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output fbfl_pkg::rsp_type              rsp_data,
   input  wire                            csr_write,
   input  wire [fbfl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [fbfl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fbfl_pkg::*;

   // Configuration.
   logic [CNT_W-1:0]   num_blocks_ff, num_blocks_in;
   logic [BYTES_W-1:0] block_bytes_ff;

   // Allocator state.
   logic [IDX_W-1:0] head_ff, head_in;
   logic             nonempty_ff, nonempty_in;
   logic [CNT_W-1:0] fresh_ff, fresh_in;
   logic [CNT_W-1:0] total_ff, total_in;

   // Item in flight between acceptance and the output register.
   logic                s1_valid_ff, s1_valid_in;
   logic                pop_ff, pop_in;
   logic [STATUS_W-1:0] s1_status_ff, s1_status_in;
   logic [IDX_W-1:0]    s1_index_ff, s1_index_in;
   logic                s1_ok_ff, s1_ok_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic             accept;
   logic             out_free;
   logic             load_out;
   logic [CNT_W-1:0] pool_size;
   logic [CNT_W-1:0] new_size;
   logic             restart;
   logic             in_range;
   link_cmd_type     link_cmd;
   link_entry_type   link_rd;
   logic [OFF_W-1:0] offset;

   fbfl_link_ram u_link_ram (
      .clock   (clock),
      .cmd     (link_cmd),
      .rd_data (link_rd)
   );

   fbfl_offset u_offset (
      .alloc_index (s1_index_ff),
      .block_bytes (block_bytes_ff),
      .granted     (s1_ok_ff),
      .byte_offset (offset)
   );

   // One item at a time; the output register decouples the result side.
   assign accept    = req_valid && !s1_valid_ff;
   assign req_stall = s1_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_out  = s1_valid_ff && out_free;

   assign pool_size = (num_blocks_ff > POOL_LIMIT) ? POOL_LIMIT : num_blocks_ff;
   assign new_size  = (csr_wdata[CNT_W-1:0] > POOL_LIMIT) ? POOL_LIMIT
                                                          : csr_wdata[CNT_W-1:0];
   assign restart   = csr_write && (csr_index == CSR_NUM_BLOCKS);
   assign in_range  = {1'b0, req_data.block_index} < pool_size;

   // The link memory is read at the head on a pop and written at the freed index on a push.
   always_comb begin
      link_cmd.rd_en               = accept && (req_data.mode == MODE_ALLOC) && nonempty_ff;
      link_cmd.rd_addr             = head_ff;
      link_cmd.wr_en               = accept && (req_data.mode == MODE_FREE) && in_range;
      link_cmd.wr_addr             = req_data.block_index;
      link_cmd.wr_data.below_valid = nonempty_ff;
      link_cmd.wr_data.next        = head_ff;
   end

   always_comb begin
      head_in      = head_ff;
      nonempty_in  = nonempty_ff;
      fresh_in     = fresh_ff;
      total_in     = total_ff;
      pop_in       = 1'b0;
      s1_valid_in  = s1_valid_ff && !load_out;
      s1_status_in = s1_status_ff;
      s1_index_in  = s1_index_ff;
      s1_ok_in     = s1_ok_ff;

      // The link read issued at acceptance returns now and becomes the new head.
      if (pop_ff) begin
         head_in     = link_rd.next;
         nonempty_in = link_rd.below_valid;
      end

      if (accept) begin
         s1_valid_in  = 1'b1;
         s1_status_in = STATUS_OK;
         s1_index_in  = '0;
         s1_ok_in     = 1'b0;
         case (req_data.mode)
            MODE_ALLOC: begin
               if (nonempty_ff) begin
                  // Freed blocks come back first, last freed first.
                  s1_index_in = head_ff;
                  s1_ok_in    = 1'b1;
                  pop_in      = 1'b1;
               end else if (fresh_ff < pool_size) begin
                  s1_index_in = fresh_ff[IDX_W-1:0];
                  s1_ok_in    = 1'b1;
                  fresh_in    = fresh_ff + CNT_W'(1);
               end else begin
                  s1_status_in = STATUS_EMPTY;
               end
               if (s1_ok_in && (total_ff != '0)) begin
                  total_in = total_ff - CNT_W'(1);
               end
            end
            MODE_FREE: begin
               if (in_range) begin
                  head_in     = req_data.block_index;
                  nonempty_in = 1'b1;
                  if (total_ff != COUNT_MAX) begin
                     total_in = total_ff + CNT_W'(1);
                  end
               end else begin
                  s1_status_in = STATUS_RANGE;
               end
            end
            default: begin
               s1_status_in = STATUS_OK;
            end
         endcase
      end

      if (restart) begin
         head_in     = '0;
         nonempty_in = 1'b0;
         fresh_in    = '0;
         total_in    = new_size;
         pop_in      = 1'b0;
      end
   end

   always_comb begin
      num_blocks_in = num_blocks_ff;
      if (restart) begin
         num_blocks_in = csr_wdata[CNT_W-1:0];
      end
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_blocks_ff  <= POOL_LIMIT;
         block_bytes_ff <= BYTES_W'(WORD_BYTES);
         head_ff        <= '0;
         nonempty_ff    <= 1'b0;
         fresh_ff       <= '0;
         total_ff       <= POOL_LIMIT;
         pop_ff         <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         num_blocks_ff <= num_blocks_in;
         if (csr_write && (csr_index == CSR_BLOCK_BYTES)) begin
            block_bytes_ff <= csr_wdata[BYTES_W-1:0];
         end
         head_ff      <= head_in;
         nonempty_ff  <= nonempty_in;
         fresh_ff     <= fresh_in;
         total_ff     <= total_in;
         pop_ff       <= pop_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item payload needs no reset.
   always_ff @(posedge clock) begin
      s1_status_ff <= s1_status_in;
      s1_index_ff  <= s1_index_in;
      s1_ok_ff     <= s1_ok_in;
      if (load_out) begin
         rsp_data_ff.status            <= s1_status_ff;
         rsp_data_ff.alloc_index       <= s1_index_ff;
         rsp_data_ff.alloc_byte_offset <= offset;
         rsp_data_ff.free_count        <= total_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

/* sv/fbfl_link_ram.sv */
`default_nettype none
module fbfl_link_ram (
   input  wire                     clock,
   input  wire fbfl_pkg::link_cmd_type cmd,
   output fbfl_pkg::link_entry_type rd_data
);
   import fbfl_pkg::*;

   link_entry_type mem [MAX_BLOCKS];
   link_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* sv/fbfl_offset.sv */
`default_nettype none
module fbfl_offset (
   input  wire [fbfl_pkg::IDX_W-1:0]   alloc_index,
   input  wire [fbfl_pkg::BYTES_W-1:0] block_bytes,
   input  wire                         granted,
   output logic [fbfl_pkg::OFF_W-1:0]  byte_offset
);
   import fbfl_pkg::*;

   localparam logic [STRIDE_W-1:0] WB = STRIDE_W'(WORD_BYTES);
   localparam logic [PROD_W-1:0]   HEADER_BYTES = PROD_W'(4 * WORD_BYTES);

   logic [STRIDE_W-1:0] padded;
   logic [STRIDE_W-1:0] stride;
   logic [PROD_W-1:0]   product;
   logic [PROD_W-1:0]   total;

   // Payload rounded up to whole words, then one header word per block.
   always_comb begin
      padded  = (STRIDE_W'(block_bytes) + WB - STRIDE_W'(1)) / WB * WB;
      stride  = padded + WB;
      product = PROD_W'(alloc_index) * PROD_W'(stride);
      total   = product + HEADER_BYTES;
      byte_offset = granted ? total[OFF_W-1:0] : '0;
   end

endmodule
`default_nettype wire
